// ----- rtl/core/command_byte_ring_queue_core_defines.svh -----
// Assertion macros shared by the command byte ring queue RTL.
// The macros expect a clock named clock and a synchronous reset named reset.
`ifndef COMMAND_BYTE_RING_QUEUE_CORE_DEFINES_SVH
`define COMMAND_BYTE_RING_QUEUE_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define CBRQ_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define CBRQ_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define CBRQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/cbrq_pkg.sv -----
// Package for the command byte ring queue: command and status codes, field
// widths and parameter defaults. No dependencies.
package cbrq_pkg;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int BYTE_W   = 8;

   // Bytes per framed command, and the counter widths that follow from it.
   localparam int CMD_BYTES = 6;
   localparam int LEFT_W    = 3;
   localparam int IDX_W     = 3;

   localparam int DEF_COMMAND_CAPACITY = 8;
   localparam int DEF_BUFFER_BYTES     = 48;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

endpackage

// ----- rtl/core/cbrq_if.sv -----
// Valid/ready channel interfaces of the command byte ring queue.
// Depends on cbrq_pkg for the field widths.
interface cbrq_req_if;
   logic                          valid;
   logic                          ready;
   logic [cbrq_pkg::CMD_W-1:0]    cmd;
   logic [cbrq_pkg::BYTE_W-1:0]   byte_in;

   modport source (output valid, output cmd, output byte_in, input ready);
   modport sink   (input valid, input cmd, input byte_in, output ready);
endinterface

interface cbrq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cbrq_pkg::STATUS_W-1:0]   status;
   logic [cbrq_pkg::BYTE_W-1:0]     removed_byte;
   logic [cbrq_pkg::BYTE_W-1:0]     reg_byte;
   logic [cbrq_pkg::BYTE_W-1:0]     action_byte;
   logic [cbrq_pkg::BYTE_W-1:0]     param_byte_0;
   logic [cbrq_pkg::BYTE_W-1:0]     param_byte_1;
   logic [cbrq_pkg::BYTE_W-1:0]     param_byte_2;
   logic [cbrq_pkg::BYTE_W-1:0]     param_byte_3;
   logic                            has_command;

   modport source (output valid, output status, output removed_byte, output reg_byte,
                   output action_byte, output param_byte_0, output param_byte_1,
                   output param_byte_2, output param_byte_3, output has_command,
                   input ready);
   modport sink   (input valid, input status, input removed_byte, input reg_byte,
                   input action_byte, input param_byte_0, input param_byte_1,
                   input param_byte_2, input param_byte_3, input has_command,
                   output ready);
endinterface

// ----- rtl/core/cbrq_pos_step.sv -----
// Ring position stepper of the command byte ring queue: one position forward
// or back with wrap-around. Shared by the write and read pointers.
module cbrq_pos_step #(
   parameter int BUFFER_BYTES = cbrq_pkg::DEF_BUFFER_BYTES
) (
   input  logic [$clog2(BUFFER_BYTES)-1:0] pos,
   input  logic                            step_back,
   output logic [$clog2(BUFFER_BYTES)-1:0] pos_out
);
   localparam int POS_W = $clog2(BUFFER_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(BUFFER_BYTES - 1);

   always_comb begin
      if (step_back) begin
         pos_out = (pos == '0) ? LAST_POS : pos - 1'b1;
      end else begin
         pos_out = (pos == LAST_POS) ? '0 : pos + 1'b1;
      end
   end
endmodule

// ----- rtl/core/command_byte_ring_queue_core.sv -----
// Command byte ring queue core: frames host bytes into six-byte commands.
// Depends on cbrq_pkg, cbrq_if.sv, cbrq_pos_step and the assertion macros.
//
// Usage: each transaction on req_chan carries a cmd (add byte, remove last
// byte, get command) and byte_in. Each accepted transaction produces exactly
// one transaction on rsp_chan with a status, the removed byte of a remove,
// the six bytes of a popped command and has_command, which tells whether a
// complete command is still stored after the operation.
// Bytes live in a single-port-write, registered-read memory of BUFFER_BYTES
// entries; a small sequencer drives it and one shared ring position stepper.
// req_chan.ready is high only while the sequencer is idle. From acceptance,
// the sequencer goes through decide to the response state for add, refused and
// unknown commands, through decide and capture for a successful remove (one
// memory read), and through decide, read and capture for a successful get (six
// memory reads, one per cycle, each advancing the read position through the
// stepper). The response state loads the output register and returns to idle.
// The response register decouples the two sides: a new request is taken
// while an earlier response still waits; if the receiver stalls, the next
// response holds in the sequencer until the register frees up.
// Reset clears the pointers, counters, sequencer and response valid; the
// byte memory is not cleared, as only written bytes are ever read back.
module command_byte_ring_queue_core #(
   parameter int COMMAND_CAPACITY = cbrq_pkg::DEF_COMMAND_CAPACITY,
   parameter int BUFFER_BYTES     = cbrq_pkg::DEF_BUFFER_BYTES
) (
   input logic        clock,
   input logic        reset,
   cbrq_req_if.sink   req_chan,
   cbrq_rsp_if.source rsp_chan
);
   import cbrq_pkg::*;

   `include "command_byte_ring_queue_core_defines.svh"

   localparam int POS_W  = $clog2(BUFFER_BYTES);
   localparam int CNT_W  = $clog2(COMMAND_CAPACITY + 1);
   localparam int HELD_W = $clog2(BUFFER_BYTES + 1);

   localparam logic [CNT_W-1:0]  CAPACITY  = CNT_W'(COMMAND_CAPACITY);
   localparam logic [HELD_W-1:0] BUF_LIMIT = HELD_W'(BUFFER_BYTES);
   localparam logic [LEFT_W-1:0] LEFT_FULL = LEFT_W'(CMD_BYTES);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CMD_BYTES - 1);

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_DECIDE  = 5'b00010,
      S_READ    = 5'b00100,
      S_CAPTURE = 5'b01000,
      S_RESP    = 5'b10000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // Ring pointers and occupancy counters.
   logic [POS_W-1:0]  wr_pos_ff, wr_pos_in;
   logic [POS_W-1:0]  rd_pos_ff, rd_pos_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [HELD_W-1:0] held_ff, held_in;

   // The accepted request and the outcome of the decide step.
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   // Byte memory with registered read port and the capture shift line.
   logic [BYTE_W-1:0] mem [BUFFER_BYTES];
   logic [BYTE_W-1:0] rdata_ff;
   logic              cap_ff;
   logic [BYTE_W-1:0] cap_bytes_ff [CMD_BYTES];
   logic              mem_we;
   logic              mem_re;
   logic [POS_W-1:0]  mem_raddr;

   // Shared position stepper.
   logic [POS_W-1:0] step_pos;
   logic             step_back;
   logic [POS_W-1:0] step_out;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [BYTE_W-1:0]   rsp_removed_ff;
   logic [BYTE_W-1:0]   rsp_cmd_ff [CMD_BYTES];
   logic                rsp_has_ff;
   logic                rsp_load;
   logic                remove_ok;
   logic                get_ok;

   logic req_accept;
   logic queue_full;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign queue_full = (count_ff >= CAPACITY) || (held_ff >= BUF_LIMIT);

   // The read pointer uses the stepper while reading; otherwise it serves the
   // write pointer, stepping back for a remove.
   assign step_pos  = (state_ff == S_READ) ? rd_pos_ff : wr_pos_ff;
   assign step_back = (state_ff == S_DECIDE) && (cmd_ff == CMD_REMOVE);

   cbrq_pos_step #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_pos_step (
      .pos       (step_pos),
      .step_back (step_back),
      .pos_out   (step_out)
   );

   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      wr_pos_in    = wr_pos_ff;
      rd_pos_in    = rd_pos_ff;
      left_in      = left_ff;
      count_in     = count_ff;
      held_in      = held_ff;
      cmd_in       = cmd_ff;
      byte_in      = byte_ff;
      status_in    = status_ff;
      idx_in       = idx_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_raddr    = rd_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in   = req_chan.cmd;
               byte_in  = req_chan.byte_in;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            status_in = ST_NONE;
            idx_in    = '0;
            state_in  = S_RESP;
            case (cmd_ff)
               CMD_ADD: begin
                  if (queue_full) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in = ST_OK;
                     mem_we    = 1'b1;
                     wr_pos_in = step_out;
                     held_in   = held_ff + 1'b1;
                     if (left_ff == LEFT_W'(1)) begin
                        left_in  = LEFT_FULL;
                        count_in = count_ff + 1'b1;
                     end else begin
                        left_in = left_ff - 1'b1;
                     end
                  end
               end
               CMD_REMOVE: begin
                  if (left_ff < LEFT_FULL) begin
                     status_in = ST_OK;
                     wr_pos_in = step_out;
                     mem_re    = 1'b1;
                     mem_raddr = step_out;
                     left_in   = left_ff + 1'b1;
                     held_in   = held_ff - 1'b1;
                     state_in  = S_CAPTURE;
                  end
               end
               CMD_GET: begin
                  if (count_ff != '0) begin
                     status_in = ST_OK;
                     count_in  = count_ff - 1'b1;
                     held_in   = held_ff - HELD_W'(CMD_BYTES);
                     state_in  = S_READ;
                  end
               end
               default: begin
                  status_in = ST_NONE;
               end
            endcase
         end
         S_READ: begin
            mem_re    = 1'b1;
            mem_raddr = rd_pos_ff;
            rd_pos_in = step_out;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_CAPTURE;
            end
         end
         S_CAPTURE: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         left_ff      <= LEFT_FULL;
         count_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         left_ff      <= left_in;
         count_ff     <= count_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= mem_re;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      byte_ff   <= byte_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
   end

   // Byte memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_pos_ff] <= byte_ff;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // Each returned byte enters at the top of the shift line, so after six
   // reads the oldest byte of the command sits at index zero. A single read
   // for a remove leaves its byte at the top.
   always_ff @(posedge clock) begin
      if (cap_ff) begin
         for (int i = 0; i < CMD_BYTES - 1; i++) begin
            cap_bytes_ff[i] <= cap_bytes_ff[i+1];
         end
         cap_bytes_ff[CMD_BYTES-1] <= rdata_ff;
      end
   end

   // Response payload; bytes that do not apply to the operation read zero.
   assign remove_ok = (status_ff == ST_OK) && (cmd_ff == CMD_REMOVE);
   assign get_ok    = (status_ff == ST_OK) && (cmd_ff == CMD_GET);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_has_ff     <= (count_ff != '0);
         rsp_removed_ff <= remove_ok ? cap_bytes_ff[CMD_BYTES-1] : '0;
         for (int i = 0; i < CMD_BYTES; i++) begin
            rsp_cmd_ff[i] <= get_ok ? cap_bytes_ff[i] : '0;
         end
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.removed_byte = rsp_removed_ff;
   assign rsp_chan.reg_byte     = rsp_cmd_ff[0];
   assign rsp_chan.action_byte  = rsp_cmd_ff[1];
   assign rsp_chan.param_byte_0 = rsp_cmd_ff[2];
   assign rsp_chan.param_byte_1 = rsp_cmd_ff[3];
   assign rsp_chan.param_byte_2 = rsp_cmd_ff[4];
   assign rsp_chan.param_byte_3 = rsp_cmd_ff[5];
   assign rsp_chan.has_command  = rsp_has_ff;

   // Terms for the checks below. The byte count always matches the complete
   // commands plus the bytes of the unfinished one.
   logic [31:0] held_expect;
   logic        left_ok;
   logic        full_answer;
   logic        last_read;
   logic        capture_now;

   assign held_expect = 32'(count_ff) * 32'(CMD_BYTES) + 32'(CMD_BYTES) - 32'(left_ff);
   assign left_ok     = (left_ff != '0) && (left_ff <= LEFT_FULL);
   assign full_answer = (state_ff == S_RESP) && (status_ff == ST_FULL);
   assign last_read   = (state_ff == S_READ) && (idx_ff == LAST_IDX);
   assign capture_now = (state_ff == S_CAPTURE) && cap_ff;

   `CBRQ_ASSERT_ALWAYS(a_held_tracks_counts, (32'(held_ff) == held_expect), "byte count off")
   `CBRQ_ASSERT_ALWAYS(a_count_in_range, (count_ff <= CAPACITY), "command count above capacity")
   `CBRQ_ASSERT_ALWAYS(a_left_in_range, left_ok, "bytes-left counter out of range")
   `CBRQ_ASSERT_IMPLIES(a_full_only_on_add, full_answer, (cmd_ff == CMD_ADD), "full without add")
   `CBRQ_ASSERT_NEXT(a_read_then_capture, last_read, capture_now, "last read not captured")

endmodule

// ----- test/command_byte_ring_queue_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for command_byte_ring_queue_core: byte, remove and get
// transactions are predicted by a behavioral model of the ring and compared per field.
// Depends on cbrq_pkg, the channel interfaces in cbrq_if.sv and the core RTL.
module command_byte_ring_queue_core_test;
   import cbrq_pkg::*;

   localparam int RING_COMMANDS = DEF_COMMAND_CAPACITY;
   localparam int RING_BYTES    = DEF_BUFFER_BYTES;
   localparam int RING_POS_W    = $clog2(RING_BYTES);
   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 8;

   localparam logic [RING_POS_W-1:0] RING_LAST = RING_POS_W'(RING_BYTES - 1);

   // Stimulus volume. A phase of random traffic runs this many counted transactions
   // before the idling and get mix change.
   localparam int ITEM_GOAL   = 1950;
   localparam int PHASE_ITEMS = 150;

   // A get is the slowest transaction in the core, and stalls and gaps add to it. The
   // limit is several times the slowest legal run, including the long hold-off.
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 30;
   localparam int HOLD_CYCLES  = 400;

   // The core ignores the fourth command code; it still answers with no result.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // One response as the core should present it. frame[0] is the register byte,
   // frame[1] the action byte and frame[2] to frame[5] the four parameter bytes.
   typedef struct packed {
      logic [STATUS_W-1:0]                 status;
      logic [BYTE_W-1:0]                   removed_byte;
      logic [CMD_BYTES-1:0][BYTE_W-1:0]    frame;
      logic                                has_command;
   } queue_answer_type;

   logic clock = 1'b0;
   logic reset;

   cbrq_req_if req_chan ();
   cbrq_rsp_if rsp_chan ();

   command_byte_ring_queue_core #(
      .COMMAND_CAPACITY(RING_COMMANDS),
      .BUFFER_BYTES    (RING_BYTES)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #HALF_PERIOD clock = ~clock;

   // Behavioral copy of the ring: byte store, both positions, the bytes still
   // missing from the command being typed, and the number of complete commands.
   logic [BYTE_W-1:0]     ring_model [RING_BYTES];
   logic [RING_POS_W-1:0] model_wr       = '0;
   logic [RING_POS_W-1:0] model_rd       = '0;
   int unsigned           model_missing  = CMD_BYTES;
   int unsigned           model_commands = 0;

   // Answers predicted at acceptance, in the order the core must return them.
   queue_answer_type awaited_answers [$];

   int unsigned mismatch_count = 0;
   int unsigned items_sent     = 0;
   int unsigned cycle_count    = 0;

   // Idling controls. The sender sends bursts of random length separated by gaps
   // of up to gap_max cycles; gap_max of zero means back-to-back transactions.
   // The receiver stalls with a chance of stall_pct percent at each new run, and a
   // nonzero hold_request makes it hold ready low for that many cycles.
   int unsigned gap_max      = 0;
   int unsigned burst_left   = 0;
   int unsigned stall_pct    = 0;
   int unsigned hold_request = 0;
   int unsigned hold_left    = 0;
   int unsigned ready_run    = 0;

   // Applies one accepted transaction to the model and returns the answer it calls for.
   function automatic queue_answer_type predict_answer(input logic [CMD_W-1:0]  cmd,
                                                       input logic [BYTE_W-1:0] data);
      queue_answer_type ans;
      ans        = '0;
      ans.status = ST_NONE;
      case (cmd)
         CMD_ADD: begin
            // Refused once the command count reaches capacity or every byte is in use.
            if (model_commands >= RING_COMMANDS ||
                model_commands * CMD_BYTES + (CMD_BYTES - model_missing) >= RING_BYTES) begin
               ans.status = ST_FULL;
            end else begin
               ring_model[model_wr] = data;
               model_wr = (model_wr == RING_LAST) ? '0 : model_wr + 1'b1;
               model_missing--;
               if (model_missing == 0) begin
                  model_commands++;
                  model_missing = CMD_BYTES;
               end
               ans.status = ST_OK;
            end
         end
         CMD_REMOVE: begin
            // Only bytes of the unfinished command can be taken back.
            if (model_missing < CMD_BYTES) begin
               model_wr = (model_wr == '0) ? RING_LAST : model_wr - 1'b1;
               ans.removed_byte = ring_model[model_wr];
               model_missing++;
               ans.status = ST_OK;
            end
         end
         CMD_GET: begin
            if (model_commands != 0) begin
               for (int i = 0; i < CMD_BYTES; i++) begin
                  ans.frame[i] = ring_model[model_rd];
                  model_rd = (model_rd == RING_LAST) ? '0 : model_rd + 1'b1;
               end
               model_commands--;
               ans.status = ST_OK;
            end
         end
         default: ;
      endcase
      ans.has_command = (model_commands != 0);
      return ans;
   endfunction

   // Offers one transaction and returns at the edge where the core accepts it. The
   // valid line stays high on return; back-to-back calls drop it only between bursts.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gap_max != 0) begin
            gap = $urandom_range(1, gap_max);
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid   <= 1'b1;
      req_chan.cmd     <= cmd;
      req_chan.byte_in <= data;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      awaited_answers.push_back(predict_answer(cmd, data));
      if (cmd != CMD_UNUSED) begin
         items_sent++;
      end
   endtask

   task automatic add_random_bytes(input int unsigned count);
      repeat (count) send_item(CMD_ADD, BYTE_W'($urandom_range(255)));
   endtask

   // Stops offering transactions and waits until every predicted answer came back.
   task automatic drain_answers();
      req_chan.valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
   endtask

   // One command as a host would type it: six bytes, sometimes with a correction
   // of stray bytes in the middle, and now and then abandoned altogether with one
   // remove too many. Leftover bytes of earlier frames shift the framing, which the
   // model follows as well.
   task automatic send_command_frame();
      int unsigned typed;
      int unsigned stray;
      int unsigned style;
      style = $urandom_range(9);
      typed = $urandom_range(0, CMD_BYTES - 1);
      add_random_bytes(typed);
      if (style == 0) begin
         repeat (typed + 1) send_item(CMD_REMOVE, BYTE_W'($urandom_range(255)));
      end else begin
         if (style < 4) begin
            stray = $urandom_range(1, 3);
            add_random_bytes(stray);
            repeat (stray) send_item(CMD_REMOVE, BYTE_W'($urandom_range(255)));
         end
         add_random_bytes(CMD_BYTES - typed);
      end
   endtask

   // Empty ring: remove and get have nothing to work on, and the unused code is
   // ignored with either extreme byte.
   task automatic test_empty_queue();
      gap_max   = 3;
      stall_pct = 30;
      send_item(CMD_REMOVE, 8'h00);
      send_item(CMD_GET, 8'hFF);
      send_item(CMD_UNUSED, 8'hFF);
      send_item(CMD_UNUSED, 8'h00);
      drain_answers();
   endtask

   // One command with extreme byte values. A complete command must not be reopened
   // by a remove, removes of an unfinished command return the newest byte first,
   // and a get returns all six bytes in order.
   task automatic test_single_command();
      send_item(CMD_ADD, 8'h00);
      send_item(CMD_ADD, 8'hFF);
      send_item(CMD_ADD, 8'h01);
      send_item(CMD_ADD, 8'h80);
      send_item(CMD_ADD, 8'h7F);
      send_item(CMD_ADD, 8'hFE);
      send_item(CMD_REMOVE, 8'hFF);
      send_item(CMD_ADD, 8'hA5);
      send_item(CMD_ADD, 8'h5A);
      send_item(CMD_REMOVE, 8'h00);
      send_item(CMD_REMOVE, 8'h00);
      send_item(CMD_REMOVE, 8'h00);
      send_item(CMD_GET, 8'h00);
      send_item(CMD_GET, 8'h00);
      drain_answers();
   endtask

   // The receiver holds off for a long stretch while bytes keep coming, so the
   // response register fills and the core stalls its input. Once released, the
   // ring fills to capacity, further bytes are refused, and after a couple of gets
   // the wrapped write position refills freed bytes before the ring is emptied again.
   task automatic test_full_and_backpressure();
      gap_max      = 0;
      stall_pct    = 0;
      hold_request = HOLD_CYCLES;
      add_random_bytes(RING_BYTES + 12);
      send_item(CMD_UNUSED, BYTE_W'($urandom_range(255)));
      send_item(CMD_REMOVE, BYTE_W'($urandom_range(255)));
      repeat (2) send_item(CMD_GET, BYTE_W'($urandom_range(255)));
      add_random_bytes(2 * CMD_BYTES + 1);
      repeat (RING_COMMANDS + 1) send_item(CMD_GET, BYTE_W'($urandom_range(255)));
      drain_answers();
   endtask

   // Mostly well-formed command frames with random content, mixed with gets and
   // random noise. Each phase changes the idling and the share of gets, so the
   // ring is driven full, drained empty and kept in between, with some phases free
   // of any idling on either side.
   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned phase_start;
      int unsigned get_pct;
      int unsigned action;
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         case (phase % 6)
            0: begin
               gap_max = 0;  stall_pct = 0;  get_pct = 50;
            end
            1: begin
               gap_max = 4;  stall_pct = 20; get_pct = 15;
            end
            2: begin
               gap_max = 10; stall_pct = 50; get_pct = 75;
            end
            3: begin
               gap_max = 2;  stall_pct = 70; get_pct = 50;
            end
            4: begin
               gap_max = 0;  stall_pct = 40; get_pct = 10;
            end
            default: begin
               gap_max = 8;  stall_pct = 0;  get_pct = 60;
            end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_GOAL) begin
            action = $urandom_range(99);
            if (action < get_pct) begin
               send_item(CMD_GET, BYTE_W'($urandom_range(255)));
            end else if (action < get_pct + 8) begin
               send_item(CMD_W'($urandom_range(3)), BYTE_W'($urandom_range(255)));
            end else begin
               send_command_frame();
            end
         end
         phase++;
      end
      drain_answers();
   endtask

   // Receiver: alternates runs of ready high and low on its own random pattern,
   // and holds ready low for a counted stretch whenever a hold-off is requested.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (ready_run != 0) begin
         ready_run--;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
         rsp_chan.ready <= 1'b0;
         ready_run = $urandom_range(0, 5);
      end else begin
         rsp_chan.ready <= 1'b1;
         ready_run = $urandom_range(0, 9);
      end
   end

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Checker: every response transaction is matched against the oldest prediction.
   always @(posedge clock) begin : check_responses
      queue_answer_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (awaited_answers.size() == 0) begin
            $display("%0t: response with nothing expected: expected none, actual status %0d",
                     $time, rsp_chan.status);
            mismatch_count++;
         end else begin
            want = awaited_answers.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_chan.status));
            compare_field("removed_byte", 32'(want.removed_byte),
                          32'(rsp_chan.removed_byte));
            compare_field("reg_byte", 32'(want.frame[0]), 32'(rsp_chan.reg_byte));
            compare_field("action_byte", 32'(want.frame[1]), 32'(rsp_chan.action_byte));
            compare_field("param_byte_0", 32'(want.frame[2]), 32'(rsp_chan.param_byte_0));
            compare_field("param_byte_1", 32'(want.frame[3]), 32'(rsp_chan.param_byte_1));
            compare_field("param_byte_2", 32'(want.frame[4]), 32'(rsp_chan.param_byte_2));
            compare_field("param_byte_3", 32'(want.frame[5]), 32'(rsp_chan.param_byte_3));
            compare_field("has_command", 32'(want.has_command), 32'(rsp_chan.has_command));
         end
      end
   end

   // Watchdog: a run that hangs anywhere ends here as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.cmd     = CMD_ADD;
      req_chan.byte_in = '0;
      rsp_chan.ready   = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_single_command();
      test_full_and_backpressure();
      test_random_traffic();

      // Give a stray extra response time to show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
